// File: src/bvc_pkg.sv
// Package for the box resize velocity controller.
// Holds the register codes, reset values, the configuration and decision
// structs and the fixed build options. Depends on nothing.
`timescale 1ns / 1ps

package bvc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam bit SIZE_GATE_ON    = 1'b1;
  localparam bit SPEED_UPDATE_ON = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_SPEED_W   = 3'd0,
    REG_MAX_SPEED_H   = 3'd1,
    REG_MAX_ACCEL_W   = 3'd2,
    REG_MAX_ACCEL_H   = 3'd3,
    REG_GROW_RATIO_W  = 3'd4,
    REG_GROW_RATIO_H  = 3'd5,
    REG_SHRINK_RATIO_W = 3'd6,
    REG_SHRINK_RATIO_H = 3'd7
  } cfg_index_t;

  localparam logic [14:0] MAX_SPEED_RESET    = 15'd1024;
  localparam logic [13:0] MAX_ACCEL_RESET    = 14'd256;
  localparam logic [15:0] GROW_RATIO_RESET   = 16'd6554;
  localparam logic [15:0] SHRINK_RATIO_RESET = 16'd13107;

  typedef struct packed {
    logic [14:0] speed_lim_w;
    logic [14:0] speed_lim_h;
    logic [13:0] accel_lim_w;
    logic [13:0] accel_lim_h;
    logic [15:0] grow_w;
    logic [15:0] grow_h;
    logic [15:0] shrink_w;
    logic [15:0] shrink_h;
  } cfg_t;

  typedef struct packed {
    logic               want_pos_w;
    logic               want_neg_w;
    logic               want_pos_h;
    logic               want_neg_h;
    logic signed [15:0] acc_w;
    logic signed [15:0] acc_h;
    logic               frozen;
    logic               frozen_load;
  } decision_t;

endpackage

// File: src/bvc_cfg_regs.sv
// Configuration register file of the box resize velocity controller.
// Depends on bvc_pkg for the register codes, reset values and cfg_t.
`timescale 1ns / 1ps

module bvc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bvc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bvc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bvc_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_lim_w <= bvc_pkg::MAX_SPEED_RESET;
      cfg.speed_lim_h <= bvc_pkg::MAX_SPEED_RESET;
      cfg.accel_lim_w <= bvc_pkg::MAX_ACCEL_RESET;
      cfg.accel_lim_h <= bvc_pkg::MAX_ACCEL_RESET;
      cfg.grow_w      <= bvc_pkg::GROW_RATIO_RESET;
      cfg.grow_h      <= bvc_pkg::GROW_RATIO_RESET;
      cfg.shrink_w    <= bvc_pkg::SHRINK_RATIO_RESET;
      cfg.shrink_h    <= bvc_pkg::SHRINK_RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (bvc_pkg::cfg_index_t'(cfg_index))
        bvc_pkg::REG_MAX_SPEED_W:    cfg.speed_lim_w <= cfg_data[14:0];
        bvc_pkg::REG_MAX_SPEED_H:    cfg.speed_lim_h <= cfg_data[14:0];
        bvc_pkg::REG_MAX_ACCEL_W:    cfg.accel_lim_w <= cfg_data[13:0];
        bvc_pkg::REG_MAX_ACCEL_H:    cfg.accel_lim_h <= cfg_data[13:0];
        bvc_pkg::REG_GROW_RATIO_W:   cfg.grow_w      <= cfg_data;
        bvc_pkg::REG_GROW_RATIO_H:   cfg.grow_h      <= cfg_data;
        bvc_pkg::REG_SHRINK_RATIO_W: cfg.shrink_w    <= cfg_data;
        bvc_pkg::REG_SHRINK_RATIO_H: cfg.shrink_h    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/bvc_thresh.sv
// Input register, threshold products and sticky-sizing decision stages.
// Depends on bvc_pkg for cfg_t, decision_t and the build options.
`timescale 1ns / 1ps

module bvc_thresh (
  input  logic                 clk,
  input  logic                 rst,
  input  bvc_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          target_width,
  input  logic [15:0]          target_height,
  input  logic [15:0]          now_width,
  input  logic [15:0]          now_height,
  input  logic                 width_priority,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output bvc_pkg::decision_t   dn_data
);

  function automatic logic signed [15:0] clamp_accel(input logic signed [16:0] d,
                                                     input logic [13:0] maxa);
    logic signed [16:0] lim;
    logic signed [16:0] neg_lim;
    logic signed [15:0] res;
    lim     = (d > 17'sd0) ? $signed({2'b00, maxa, 1'b0}) : $signed({3'b000, maxa});
    neg_lim = -lim;
    if (d > lim) begin
      res = lim[15:0];
    end else if (d < neg_lim) begin
      res = neg_lim[15:0];
    end else begin
      res = d[15:0];
    end
    return res;
  endfunction

  // Stage one: input register.
  logic               v1;
  logic signed [16:0] dw1, dh1;
  logic [15:0]        nw1, nh1;
  logic               prio1;

  // Stage two: products of current size and ratios.
  logic               v2;
  logic signed [16:0] dw2, dh2;
  logic [31:0]        pgw2, pgh2, psw2, psh2;
  logic               prio2;

  logic rdy1, rdy2, rdy3;

  assign rdy3     = !dn_valid || dn_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      dw1   <= $signed({1'b0, target_width})  - $signed({1'b0, now_width});
      dh1   <= $signed({1'b0, target_height}) - $signed({1'b0, now_height});
      nw1   <= now_width;
      nh1   <= now_height;
      prio1 <= width_priority;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      dw2   <= dw1;
      dh2   <= dh1;
      pgw2  <= 32'(nw1) * 32'(cfg.grow_w);
      pgh2  <= 32'(nh1) * 32'(cfg.grow_h);
      psw2  <= 32'(nw1) * 32'(cfg.shrink_w);
      psh2  <= 32'(nh1) * 32'(cfg.shrink_h);
      prio2 <= prio1;
    end
  end

  logic [15:0]        magw, magh;
  logic               posw, negw, posh, negh;
  logic               big_w, big_h, ok_w, ok_h, use_w, use_h;
  logic               both, any_ok, bigger;
  logic signed [16:0] dwm, dhm;
  bvc_pkg::decision_t dec_next;

  always_comb begin
    magw  = dw2[16] ? 16'(-dw2) : dw2[15:0];
    magh  = dh2[16] ? 16'(-dh2) : dh2[15:0];
    posw  = !dw2[16] && (dw2 != 17'sd0);
    negw  = dw2[16];
    posh  = !dh2[16] && (dh2 != 17'sd0);
    negh  = dh2[16];
    big_w = posw && ({magw, 16'h0000} > pgw2);
    big_h = posh && ({magh, 16'h0000} > pgh2);
    ok_w  = (negw && ({magw, 16'h0000} > psw2)) || big_w;
    ok_h  = (negh && ({magh, 16'h0000} > psh2)) || big_h;
    both   = (ok_w && ok_h) || (prio2 && ok_w);
    any_ok = ok_w || ok_h;
    bigger = (big_w || big_h) && any_ok;
    use_w  = bvc_pkg::SIZE_GATE_ON ? ok_w : 1'b1;
    use_h  = bvc_pkg::SIZE_GATE_ON ? ok_h : 1'b1;
    dwm    = use_w ? dw2 : 17'sd0;
    dhm    = use_h ? dh2 : 17'sd0;
    dec_next.want_pos_w  = posw && use_w;
    dec_next.want_neg_w  = negw && use_w;
    dec_next.want_pos_h  = posh && use_h;
    dec_next.want_neg_h  = negh && use_h;
    dec_next.acc_w       = clamp_accel(dwm, cfg.accel_lim_w);
    dec_next.acc_h       = clamp_accel(dhm, cfg.accel_lim_h);
    dec_next.frozen      = (!ok_w && !ok_h) || !(both || bigger);
    dec_next.frozen_load = bvc_pkg::SIZE_GATE_ON;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (rdy3) begin
      dn_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      dn_data <= dec_next;
    end
  end

endmodule

// File: src/bvc_update.sv
// Speed state, braking, acceleration and the result register.
// Depends on bvc_pkg for cfg_t, decision_t and the build options.
`timescale 1ns / 1ps

module bvc_update (
  input  logic                      clk,
  input  logic                      rst,
  input  bvc_pkg::cfg_t             cfg,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  bvc_pkg::decision_t        up_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [15:0]        speed_width,
  output logic signed [15:0]        speed_height,
  output logic                      frozen,
  output logic signed [14:0]        step_width,
  output logic signed [14:0]        step_height
);

  function automatic logic signed [15:0] half16(input logic signed [15:0] s);
    logic [16:0] t;
    t = {s[15], s} + {16'h0000, s[15]};
    return t[16:1];
  endfunction

  function automatic logic signed [15:0] brake(input logic signed [15:0] s,
                                               input logic want_pos,
                                               input logic want_neg,
                                               input logic [14:0] maxs);
    logic               opp;
    logic [15:0]        mag;
    logic [17:0]        m6;
    logic signed [15:0] res;
    opp = (want_pos && s < 16'sd0) || (want_neg && s > 16'sd0);
    mag = s[15] ? 16'(-s) : s;
    m6  = {mag, 2'b00} + {1'b0, mag, 1'b0};
    if (!opp) begin
      res = s;
    end else if (m6 < 18'(maxs)) begin
      res = 16'sd0;
    end else begin
      res = half16(s);
    end
    return res;
  endfunction

  function automatic logic signed [15:0] accelerate(input logic signed [15:0] s,
                                                    input logic signed [15:0] a,
                                                    input logic [14:0] maxs);
    logic signed [16:0] sum;
    logic signed [16:0] lim;
    logic signed [16:0] neg_lim;
    logic signed [15:0] res;
    sum     = $signed({s[15], s}) + $signed({a[15], a});
    lim     = $signed({2'b00, maxs});
    neg_lim = -lim;
    if (sum > lim) begin
      res = lim[15:0];
    end else if (sum < neg_lim) begin
      res = neg_lim[15:0];
    end else begin
      res = sum[15:0];
    end
    return res;
  endfunction

  logic signed [15:0] wspeed, hspeed;
  logic               frz;
  logic               fire;
  logic               frz_eff, frz_next;
  logic signed [15:0] bw, bh, wspeed_next, hspeed_next, hw, hh;

  assign up_ready = !out_valid || !out_stall;
  assign fire     = up_valid && up_ready;

  always_comb begin
    frz_eff = up_data.frozen_load ? up_data.frozen : frz;
    bw = brake(wspeed, up_data.want_pos_w, up_data.want_neg_w, cfg.speed_lim_w);
    bh = brake(hspeed, up_data.want_pos_h, up_data.want_neg_h, cfg.speed_lim_h);
    if (!bvc_pkg::SPEED_UPDATE_ON) begin
      wspeed_next = wspeed;
      hspeed_next = hspeed;
      frz_next    = frz;
    end else if (frz_eff) begin
      wspeed_next = bw;
      hspeed_next = bh;
      frz_next    = 1'b1;
    end else begin
      wspeed_next = accelerate(bw, up_data.acc_w, cfg.speed_lim_w);
      hspeed_next = accelerate(bh, up_data.acc_h, cfg.speed_lim_h);
      frz_next    = 1'b0;
    end
    hw = half16(wspeed_next);
    hh = half16(hspeed_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wspeed    <= 16'sd0;
      hspeed    <= 16'sd0;
      frz       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        out_valid <= up_valid;
      end
      if (fire) begin
        wspeed <= wspeed_next;
        hspeed <= hspeed_next;
        frz    <= frz_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      speed_width  <= wspeed_next;
      speed_height <= hspeed_next;
      frozen       <= frz_next;
      step_width   <= frz_next ? 15'sd0 : hw[14:0];
      step_height  <= frz_next ? 15'sd0 : hh[14:0];
    end
  end

  a_frozen_no_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && frozen |-> step_width == 15'sd0 && step_height == 15'sd0)
    else $error("step reported while frozen");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_width == wspeed && speed_height == hspeed && frozen == frz)
    else $error("result register differs from speed state");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(wspeed) && $stable(hspeed) && $stable(frz))
    else $error("speed state changed without a transfer");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_width != 16'sh8000 && speed_height != 16'sh8000)
    else $error("speed magnitude out of range");

endmodule

// File: src/box_resize_velocity_controller.sv
// Top level of the box resize velocity controller.
// Depends on bvc_pkg, bvc_cfg_regs, bvc_thresh and bvc_update.
//
//   channel   handshake            payload
//   input     in_valid / in_stall   target_width/height, now_width/height, width_priority
//   result    out_valid / out_stall speed_width/height, frozen, step_width/height
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is accepted every cycle unless a held result backs up the stages.
// The speed update sets the pace: it reads and writes the speed state in the same cycle.
// Reset clears the speeds, the frozen flag and the pipeline, and restores register defaults.
// A stalled result holds; items behind it keep moving into empty stages first.
`timescale 1ns / 1ps

module box_resize_velocity_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      target_width,
  input  logic [15:0]                      target_height,
  input  logic [15:0]                      now_width,
  input  logic [15:0]                      now_height,
  input  logic                             width_priority,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               speed_width,
  output logic signed [15:0]               speed_height,
  output logic                             frozen,
  output logic signed [14:0]               step_width,
  output logic signed [14:0]               step_height,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bvc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bvc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bvc_pkg::cfg_t      cfg;
  bvc_pkg::decision_t dec;
  logic               dec_valid, dec_ready;

  bvc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bvc_thresh u_thresh (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_width   (target_width),
    .target_height  (target_height),
    .now_width      (now_width),
    .now_height     (now_height),
    .width_priority (width_priority),
    .dn_valid       (dec_valid),
    .dn_ready       (dec_ready),
    .dn_data        (dec)
  );

  bvc_update u_update (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .up_valid     (dec_valid),
    .up_ready     (dec_ready),
    .up_data      (dec),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .speed_width  (speed_width),
    .speed_height (speed_height),
    .frozen       (frozen),
    .step_width   (step_width),
    .step_height  (step_height)
  );

endmodule

// File: sim/bvc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the box resize velocity controller: follows register writes,
// input and result transfers, predicts every result and compares it field by field.
// Depends on bvc_pkg.

module bvc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [15:0]                     target_width,
  input  logic [15:0]                     target_height,
  input  logic [15:0]                     now_width,
  input  logic [15:0]                     now_height,
  input  logic                            width_priority,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [15:0]              speed_width,
  input  logic signed [15:0]              speed_height,
  input  logic                            frozen,
  input  logic signed [14:0]              step_width,
  input  logic signed [14:0]              step_height,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bvc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bvc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);

  typedef struct packed {
    logic signed [15:0] speed_w;
    logic signed [15:0] speed_h;
    logic               frz;
    logic signed [14:0] step_w;
    logic signed [14:0] step_h;
  } motion_t;

  bvc_pkg::cfg_t      cfg;
  logic signed [16:0] width_vel;
  logic signed [16:0] height_vel;
  logic               frz_state;
  motion_t            motion_q[$];
  int                 errs = 0;
  int                 n_checked = 0;

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // A speed that works against the wanted change is dropped when small, else halved.
  function automatic longint brake_speed(input longint spd, input longint want,
                                         input longint top);
    if ((want < 0 && spd > 0) || (want > 0 && spd < 0)) begin
      if ((spd < 0 ? -spd : spd) * 6 < top) return 0;
      return spd / 2;
    end
    return spd;
  endfunction

  // Growth may accelerate at twice the limit that applies to shrinking.
  function automatic longint push_speed(input longint spd, input longint want,
                                        input longint acc_max, input longint top);
    return clip(spd + clip(want, want > 0 ? 2 * acc_max : acc_max), top);
  endfunction

  function automatic motion_t next_motion(input logic [15:0] tw, th, nw, nh,
                                          input logic prio);
    longint  dw, dh, ws, hs;
    bit      big_w, big_h, ok_w, ok_h;
    motion_t m;
    dw = longint'(tw) - longint'(nw);
    dh = longint'(th) - longint'(nh);
    ws = width_vel;
    hs = height_vel;
    if (bvc_pkg::SPEED_UPDATE_ON) begin
      if (bvc_pkg::SIZE_GATE_ON) begin
        // Differences scaled by 2^16 compare exactly against size times a Q0.16 ratio.
        big_w = dw > 0 && dw * 65536 > longint'(nw) * longint'(cfg.grow_w);
        big_h = dh > 0 && dh * 65536 > longint'(nh) * longint'(cfg.grow_h);
        ok_w = (dw < 0 && -dw * 65536 > longint'(nw) * longint'(cfg.shrink_w)) || big_w;
        ok_h = (dh < 0 && -dh * 65536 > longint'(nh) * longint'(cfg.shrink_h)) || big_h;
        if (!ok_w) dw = 0;
        if (!ok_h) dh = 0;
        frz_state = (!ok_w && !ok_h) ||
                    !((ok_w && ok_h) || (prio && ok_w) ||
                      ((big_w || big_h) && (ok_w || ok_h)));
      end
      ws = brake_speed(ws, dw, cfg.speed_lim_w);
      hs = brake_speed(hs, dh, cfg.speed_lim_h);
      if (!frz_state) begin
        ws = push_speed(ws, dw, cfg.accel_lim_w, cfg.speed_lim_w);
        hs = push_speed(hs, dh, cfg.accel_lim_h, cfg.speed_lim_h);
      end
    end
    width_vel = 17'(ws);
    height_vel = 17'(hs);
    m.speed_w = 16'(ws);
    m.speed_h = 16'(hs);
    m.frz = frz_state;
    m.step_w = frz_state ? '0 : 15'(ws / 2);
    m.step_h = frz_state ? '0 : 15'(hs / 2);
    return m;
  endfunction

  task automatic compare_field(input string name, input logic signed [15:0] exp_v, act_v);
    if (act_v !== exp_v) begin
      if (errs < 40) $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    motion_t want;
    if (rst) begin
      cfg.speed_lim_w = bvc_pkg::MAX_SPEED_RESET;
      cfg.speed_lim_h = bvc_pkg::MAX_SPEED_RESET;
      cfg.accel_lim_w = bvc_pkg::MAX_ACCEL_RESET;
      cfg.accel_lim_h = bvc_pkg::MAX_ACCEL_RESET;
      cfg.grow_w = bvc_pkg::GROW_RATIO_RESET;
      cfg.grow_h = bvc_pkg::GROW_RATIO_RESET;
      cfg.shrink_w = bvc_pkg::SHRINK_RATIO_RESET;
      cfg.shrink_h = bvc_pkg::SHRINK_RATIO_RESET;
      width_vel = '0;
      height_vel = '0;
      frz_state = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (motion_q.size() == 0) begin
          if (errs < 40)
            $display("%0t: unexpected result, expected none, got speed %0d/%0d step %0d/%0d",
                     $time, speed_width, speed_height, step_width, step_height);
          errs++;
        end else begin
          want = motion_q.pop_front();
          compare_field("speed_width", want.speed_w, speed_width);
          compare_field("speed_height", want.speed_h, speed_height);
          compare_field("frozen", 16'(want.frz), 16'(frozen));
          compare_field("step_width", 16'(want.step_w), 16'(step_width));
          compare_field("step_height", 16'(want.step_h), 16'(step_height));
          n_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (bvc_pkg::cfg_index_t'(cfg_index))
          bvc_pkg::REG_MAX_SPEED_W:    cfg.speed_lim_w = cfg_data[14:0];
          bvc_pkg::REG_MAX_SPEED_H:    cfg.speed_lim_h = cfg_data[14:0];
          bvc_pkg::REG_MAX_ACCEL_W:    cfg.accel_lim_w = cfg_data[13:0];
          bvc_pkg::REG_MAX_ACCEL_H:    cfg.accel_lim_h = cfg_data[13:0];
          bvc_pkg::REG_GROW_RATIO_W:   cfg.grow_w = cfg_data;
          bvc_pkg::REG_GROW_RATIO_H:   cfg.grow_h = cfg_data;
          bvc_pkg::REG_SHRINK_RATIO_W: cfg.shrink_w = cfg_data;
          bvc_pkg::REG_SHRINK_RATIO_H: cfg.shrink_h = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        motion_q.push_back(next_motion(target_width, target_height, now_width, now_height,
                                       width_priority));
    end
    fail_count <= errs;
    pending <= motion_q.size();
    checked <= n_checked;
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the box resize velocity controller: clock, reset, stimulus
// on the input, register and result channels, and the final verdict.
// Depends on bvc_pkg, box_resize_velocity_controller and bvc_checker.

module tb;

  localparam int            PHASE_ITEMS = 200;
  localparam int            N_PHASES    = 6;
  localparam int            CYCLE_LIMIT = 400000;
  localparam bvc_pkg::cfg_t DEFAULT_CFG = '{bvc_pkg::MAX_SPEED_RESET,
                                            bvc_pkg::MAX_SPEED_RESET,
                                            bvc_pkg::MAX_ACCEL_RESET,
                                            bvc_pkg::MAX_ACCEL_RESET,
                                            bvc_pkg::GROW_RATIO_RESET,
                                            bvc_pkg::GROW_RATIO_RESET,
                                            bvc_pkg::SHRINK_RATIO_RESET,
                                            bvc_pkg::SHRINK_RATIO_RESET};

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [15:0]                     target_width = '0;
  logic [15:0]                     target_height = '0;
  logic [15:0]                     now_width = '0;
  logic [15:0]                     now_height = '0;
  logic                            width_priority = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [15:0]              speed_width;
  logic signed [15:0]              speed_height;
  logic                            frozen;
  logic signed [14:0]              step_width;
  logic signed [14:0]              step_height;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bvc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bvc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  int                              fail_count;
  int                              pending;
  int                              checked;
  int                              cycles = 0;
  int                              sent = 0;
  int                              settings = 0;
  int                              stall_left = 0;
  bvc_pkg::cfg_t                   cur_cfg = DEFAULT_CFG;

  box_resize_velocity_controller u_dut (.*);
  bvc_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver mixes short stalls, long stalls and long stall-free stretches.
  always @(posedge clk) begin
    int pick;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else if (pick < 85) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (pick < 95) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(20, 60);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(8, 30);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom);
    if (r < 8) return 16'($urandom_range(16, 4000));
    return 16'($urandom_range(0, 64));
  endfunction

  // Trend 0 favours growth, 1 shrinking, 2 either; three picks in ten sit on or beside
  // the sticky threshold.
  function automatic logic [15:0] pick_target(input logic [15:0] now,
                                              input logic [15:0] grow, shrink,
                                              input int trend);
    longint d;
    int     r;
    bit     up;
    r = $urandom_range(0, 9);
    up = (trend == 0) || (trend == 2 && $urandom_range(0, 1) == 1);
    if (r == 0) return 16'($urandom);
    if (r < 4)
      d = ((longint'(now) * longint'(up ? grow : shrink)) >> 16) +
          longint'($urandom_range(0, 2)) - 1;
    else if (r < 8)
      d = longint'($urandom_range(0, (now >> 1) + 40));
    else
      d = longint'($urandom_range(0, 40));
    d = up ? longint'(now) + d : longint'(now) - d;
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return 16'(d);
  endfunction

  task automatic put_item(input logic [15:0] tw, th, nw, nh, input logic prio,
                          input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target_width <= tw;
    target_height <= th;
    now_width <= nw;
    now_height <= nh;
    width_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes every register in one burst; the unused upper data bits carry noise.
  task automatic load_config(input bvc_pkg::cfg_t c);
    logic [bvc_pkg::CFG_DATA_W-1:0] vals[8];
    bvc_pkg::cfg_index_t            r;
    drain();
    vals[bvc_pkg::REG_MAX_SPEED_W] = {1'($urandom), c.speed_lim_w};
    vals[bvc_pkg::REG_MAX_SPEED_H] = {1'($urandom), c.speed_lim_h};
    vals[bvc_pkg::REG_MAX_ACCEL_W] = {2'($urandom), c.accel_lim_w};
    vals[bvc_pkg::REG_MAX_ACCEL_H] = {2'($urandom), c.accel_lim_h};
    vals[bvc_pkg::REG_GROW_RATIO_W] = c.grow_w;
    vals[bvc_pkg::REG_GROW_RATIO_H] = c.grow_h;
    vals[bvc_pkg::REG_SHRINK_RATIO_W] = c.shrink_w;
    vals[bvc_pkg::REG_SHRINK_RATIO_H] = c.shrink_h;
    r = r.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data <= vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_valid <= 1'b0;
    cur_cfg = c;
    settings++;
  endtask

  initial begin
    bvc_pkg::cfg_t c;
    int   trend_w;
    int   trend_h;
    logic [15:0] nw;
    logic [15:0] nh;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed cases under the reset register values.
    put_item(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    repeat (3) put_item(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0);
    put_item(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    put_item(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    put_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    put_item(16'd2000, 16'd1000, 16'd1000, 16'd1000, 1'b0, 1'b0);
    put_item(16'd500, 16'd1000, 16'd1000, 16'd1000, 1'b0, 1'b0);
    put_item(16'd500, 16'd1000, 16'd1000, 16'd1000, 1'b1, 1'b0);
    put_item(16'd1000, 16'd500, 16'd1000, 16'd1000, 1'b1, 1'b0);
    put_item(16'd1000, 16'd2000, 16'd1000, 16'd1000, 1'b0, 1'b0);
    // Growth exactly on and just past its sticky threshold; shrinking just short of and past its own.
    put_item(16'd36045, 16'd36045, 16'd32768, 16'd32768, 1'b1, 1'b0);
    put_item(16'd36046, 16'd36046, 16'd32768, 16'd32768, 1'b1, 1'b0);
    put_item(16'd26215, 16'd26215, 16'd32768, 16'd32768, 1'b1, 1'b0);
    put_item(16'd26214, 16'd26214, 16'd32768, 16'd32768, 1'b1, 1'b0);
    // Growth moves build up a speed, then small opposing moves drop it to zero and reverse it.
    repeat (6) put_item(16'd120, 16'd120, 16'd100, 16'd100, 1'b1, 1'b1);
    repeat (2) put_item(16'd70, 16'd70, 16'd100, 16'd100, 1'b1, 1'b0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: c = DEFAULT_CFG;
        1: c = '{15'h7FFF, 15'h7FFF, 14'h3FFF, 14'h3FFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: c = '0;
        3: begin
          c.speed_lim_w = 15'($urandom);
          c.speed_lim_h = 15'($urandom);
          c.accel_lim_w = 14'($urandom);
          c.accel_lim_h = 14'($urandom);
          c.grow_w = 16'($urandom);
          c.grow_h = 16'($urandom);
          c.shrink_w = 16'($urandom);
          c.shrink_h = 16'($urandom);
        end
        4: begin
          c.speed_lim_w = 15'($urandom_range(0, 600));
          c.speed_lim_h = 15'($urandom_range(0, 600));
          c.accel_lim_w = 14'($urandom_range(0, 200));
          c.accel_lim_h = 14'($urandom_range(0, 200));
          c.grow_w = 16'($urandom_range(0, 20000));
          c.grow_h = 16'($urandom_range(0, 20000));
          c.shrink_w = 16'($urandom_range(0, 20000));
          c.shrink_h = 16'($urandom_range(0, 20000));
        end
        default: c = '{15'h7FFF, 15'h7FFF, 14'd1, 14'h3FFF,
                       16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
      endcase
      load_config(c);
      trend_w = 2;
      trend_h = 2;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) begin
          trend_w = $urandom_range(0, 2);
          trend_h = $urandom_range(0, 2);
        end
        if (n == PHASE_ITEMS / 2) drain();
        nw = pick_size();
        nh = pick_size();
        put_item(pick_target(nw, cur_cfg.grow_w, cur_cfg.shrink_w, trend_w),
                 pick_target(nh, cur_cfg.grow_h, cur_cfg.shrink_h, trend_h),
                 nw, nh, 1'($urandom), n % 150 < 40);
      end
    end

    drain();
    $display("Run summary: %0d input transfers, %0d results checked, %0d register settings.",
             sent, checked, settings);
    $display("Covered default, largest, zero and random limits and ratios, threshold edges.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
